>>> rtl/ipv4p_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ipv4p_pkg;

  // Character codes the parser reacts to
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Octet limits
  localparam logic [11:0] OCTET_MAX  = 12'd255;
  localparam logic [1:0]  MAX_DIGITS = 2'd3;
  localparam logic [1:0]  LAST_OCTET = 2'd3;

  // Result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  // One input character
  typedef struct packed {
    logic [7:0] char_code;
    logic       first_char;
  } in_item_t;

  // One parse result
  typedef struct packed {
    logic        status;
    logic [31:0] address;
  } out_item_t;

  // Running parse state
  typedef struct packed {
    logic        parsing_active;
    logic [1:0]  octet_position;
    logic        awaiting_digit;
    logic [1:0]  digit_count;
    logic [7:0]  octet_value;
    logic [23:0] upper_octets;
  } parse_state_t;

endpackage

`default_nettype wire

>>> rtl/ipv4_dotted_decimal_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Dotted-decimal IPv4 address parser.
// Input channel (in_valid_i/in_ready_o/in_data_i) carries one character per
// transaction; first_char set starts a new string and drops any parse in progress.
// Output channel (out_valid_o/out_ready_i/out_data_o) carries at most one result
// per string: status ok with the packed address once the fourth octet is followed
// by NUL or space, or status error with address zero at the first malformed
// character. Afterward characters are ignored until the next first_char.
// An accepted character first loads the input register; any result it yields
// loads the result register as the character moves on and shows at out_valid_o.
// Throughput: one character per cycle when not stalled; the parse state update is
// a short multiply-by-ten, add and compare between the input and result registers.
// Reset: both registers empty, parser idle until a first_char transaction.
// Stall: while out_ready_i is low and a result is pending, the input register
// still drains characters that give no result; in_ready_o drops only when the
// input register holds a character that cannot move on.
module ipv4_dotted_decimal_parser_unit (
  input  var logic                 clk_i,
  input  var logic                 rst_ni,
  input  var logic                 in_valid_i,
  output logic                     in_ready_o,
  input  var ipv4p_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  var logic                 out_ready_i,
  output ipv4p_pkg::out_item_t     out_data_o
);

  logic                    in_valid_q;
  ipv4p_pkg::in_item_t     in_q;
  ipv4p_pkg::parse_state_t state_q;
  ipv4p_pkg::parse_state_t state_d;
  logic                    out_valid_q;
  ipv4p_pkg::out_item_t    out_q;
  logic                    step_valid;
  ipv4p_pkg::out_item_t    step_res;
  logic                    out_free;
  logic                    advance;

  // A character moves on when it yields no result or the result slot is free
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!step_valid || out_free);
  assign in_ready_o = !in_valid_q || advance;

  ipv4p_step u_step (
    .state_i     (state_q),
    .item_i      (in_q),
    .state_o     (state_d),
    .res_valid_o (step_valid),
    .res_o       (step_res)
  );

  // Capture the next character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Update the parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.parsing_active <= 1'b0;
      state_q.octet_position <= 2'd0;
      state_q.awaiting_digit <= 1'b1;
      state_q.digit_count    <= 2'd0;
      state_q.octet_value    <= 8'd0;
      state_q.upper_octets   <= 24'd0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && step_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && advance && step_valid) begin
      out_q <= step_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // Error results always carry a zero address
  a_error_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ipv4p_pkg::STATUS_ERROR) |-> out_data_o.address == 32'd0)
    else $error("error result with nonzero address");

  // A result ends the parse
  a_result_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && step_valid) |=> !state_q.parsing_active)
    else $error("parser still active after a result");

  // A stalled character holds in the input register
  a_input_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_q)))
    else $error("stalled character lost");

  // A start character without a result leaves the parser active
  a_start_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.first_char && !step_valid) |=> state_q.parsing_active)
    else $error("start character did not activate parse");
`endif

endmodule

`default_nettype wire

>>> rtl/ipv4p_step.sv
`timescale 1ns / 1ps
`default_nettype none

module ipv4p_step (
  input  var ipv4p_pkg::parse_state_t state_i,
  input  var ipv4p_pkg::in_item_t     item_i,
  output ipv4p_pkg::parse_state_t     state_o,
  output logic                        res_valid_o,
  output ipv4p_pkg::out_item_t        res_o
);

  ipv4p_pkg::parse_state_t cur;
  logic                    is_digit;
  logic [3:0]              digit;
  logic [11:0]             value_x10;

  // Restart on a start flag, then decode the character
  always_comb begin
    cur = state_i;
    if (item_i.first_char) begin
      cur.parsing_active = 1'b1;
      cur.octet_position = 2'd0;
      cur.awaiting_digit = 1'b1;
      cur.digit_count    = 2'd0;
      cur.octet_value    = 8'd0;
      cur.upper_octets   = 24'd0;
    end
  end

  assign is_digit  = (item_i.char_code >= ipv4p_pkg::CHAR_ZERO) &&
                     (item_i.char_code <= ipv4p_pkg::CHAR_NINE);
  assign digit     = 4'(item_i.char_code - ipv4p_pkg::CHAR_ZERO);
  // value * 10 + digit as shift-and-add
  assign value_x10 = {1'b0, cur.octet_value, 3'b000} + {3'b000, cur.octet_value, 1'b0}
                     + {8'd0, digit};

  // Advance the parse by one character
  always_comb begin
    state_o       = cur;
    res_valid_o   = 1'b0;
    res_o.status  = ipv4p_pkg::STATUS_ERROR;
    res_o.address = 32'd0;
    if (cur.parsing_active) begin
      if (is_digit) begin
        if (cur.digit_count == ipv4p_pkg::MAX_DIGITS || value_x10 > ipv4p_pkg::OCTET_MAX) begin
          res_valid_o = 1'b1;
        end else begin
          state_o.octet_value    = value_x10[7:0];
          state_o.digit_count    = cur.digit_count + 2'd1;
          state_o.awaiting_digit = 1'b0;
        end
      end else if (cur.awaiting_digit) begin
        res_valid_o = 1'b1;
      end else if (cur.octet_position != ipv4p_pkg::LAST_OCTET) begin
        if (item_i.char_code != ipv4p_pkg::CHAR_DOT) begin
          res_valid_o = 1'b1;
        end else begin
          state_o.upper_octets   = {cur.upper_octets[15:0], cur.octet_value};
          state_o.octet_position = cur.octet_position + 2'd1;
          state_o.awaiting_digit = 1'b1;
          state_o.digit_count    = 2'd0;
          state_o.octet_value    = 8'd0;
        end
      end else begin
        // Fourth octet done: only NUL or space terminates cleanly
        res_valid_o = 1'b1;
        if (item_i.char_code == ipv4p_pkg::CHAR_NUL ||
            item_i.char_code == ipv4p_pkg::CHAR_SPACE) begin
          res_o.status  = ipv4p_pkg::STATUS_OK;
          res_o.address = {cur.upper_octets, cur.octet_value};
        end
      end
    end
    // Drop to idle after any result
    if (res_valid_o) begin
      state_o.parsing_active = 1'b0;
    end
  end

endmodule

`default_nettype wire
